// ===== src/lslf_pkg.sv =====
// shared widths, codes and interface types of the line fit block
package lslf_pkg;

    // sample limits and fixed-point format
    localparam int MAX_SAMPLES = 1024;
    localparam int FRAC_BITS   = 16;
    localparam int X_W         = 16;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int SX_W        = X_W + CNT_W;
    localparam int SXX_W       = 2 * X_W + CNT_W;
    localparam int COEF_W      = 48;
    localparam int PRED_W      = 32;

    // shared unit operand and result widths
    localparam int MULA_W = (SXX_W > COEF_W) ? SXX_W : COEF_W;
    localparam int MULB_W = SX_W;
    localparam int PROD_W = MULA_W + MULB_W;
    localparam int D_W    = CNT_W + SXX_W;
    localparam int OPR_W  = (D_W > MULA_W) ? D_W : MULA_W;
    localparam int ALU_W  = (PROD_W > D_W) ? PROD_W : D_W + 1;
    localparam int DIVN_W = PROD_W + FRAC_BITS;
    localparam int ITER_W = $clog2(DIVN_W);

    // prediction accumulator and its scaled-down form
    localparam int ACC_W = COEF_W + X_W + 1;
    localparam int Q_W   = ACC_W - FRAC_BITS;

    localparam logic [PRED_W-1:0] DEFAULT_PREDICTION = PRED_W'(1000);

    // shared unit operation codes
    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } t_unit_op;

    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

// ===== src/lslf_seq_unit.sv =====
// shared bit-serial multiply and restoring divide unit around one wide adder
module lslf_seq_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lslf_pkg::t_unit_req             i_req,
    input  logic [lslf_pkg::MULA_W-1:0]     i_mul_a,
    input  logic [lslf_pkg::MULB_W-1:0]     i_mul_b,
    input  logic [lslf_pkg::DIVN_W-1:0]     i_div_n,
    input  logic [lslf_pkg::D_W-1:0]        i_div_d,
    output lslf_pkg::t_unit_sts             o_sts,
    output logic [lslf_pkg::PROD_W-1:0]     o_prod,
    output logic [lslf_pkg::DIVN_W-1:0]     o_quot
);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    lslf_pkg::t_unit_op             r_op, n_op;
    logic [lslf_pkg::ITER_W-1:0]    r_cnt, n_cnt;
    logic [lslf_pkg::ALU_W-1:0]     r_acc, n_acc;
    logic [lslf_pkg::DIVN_W-1:0]    r_sh, n_sh;
    logic [lslf_pkg::OPR_W-1:0]     r_opr, n_opr;

    logic                           top_bit;
    logic [lslf_pkg::ALU_W-1:0]     add_a, add_b;
    logic                           add_cin;
    logic [lslf_pkg::ALU_W:0]       add_sum;
    logic                           ge;
    logic                           last_step;

    // the one adder: shift-add step or trial subtract
    always_comb begin
        top_bit = r_sh[lslf_pkg::DIVN_W-1];
        if (r_op == lslf_pkg::OP_MUL) begin
            add_a   = {r_acc[lslf_pkg::ALU_W-2:0], 1'b0};
            add_b   = top_bit ? lslf_pkg::ALU_W'(r_opr) : '0;
            add_cin = 1'b0;
        end else begin
            add_a   = lslf_pkg::ALU_W'({r_acc[lslf_pkg::D_W-1:0], top_bit});
            add_b   = ~lslf_pkg::ALU_W'(r_opr);
            add_cin = 1'b1;
        end
        add_sum = {1'b0, add_a} + {1'b0, add_b} + (lslf_pkg::ALU_W + 1)'(add_cin);
        ge      = add_sum[lslf_pkg::ALU_W];
    end

    // iteration count and next state
    always_comb begin
        last_step = (r_op == lslf_pkg::OP_MUL)
                  ? (r_cnt == lslf_pkg::ITER_W'(lslf_pkg::MULB_W - 1))
                  : (r_cnt == lslf_pkg::ITER_W'(lslf_pkg::DIVN_W - 1));
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_sh   = r_sh;
        n_opr  = r_opr;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_cnt  = '0;
            n_acc  = '0;
            if (i_req.op == lslf_pkg::OP_MUL) begin
                n_sh  = {i_mul_b, {(lslf_pkg::DIVN_W - lslf_pkg::MULB_W){1'b0}}};
                n_opr = lslf_pkg::OPR_W'(i_mul_a);
            end else begin
                n_sh  = i_div_n;
                n_opr = lslf_pkg::OPR_W'(i_div_d);
            end
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            if (r_op == lslf_pkg::OP_MUL) begin
                n_acc = add_sum[lslf_pkg::ALU_W-1:0];
                n_sh  = {r_sh[lslf_pkg::DIVN_W-2:0], 1'b0};
            end else begin
                n_acc = ge ? add_sum[lslf_pkg::ALU_W-1:0] : add_a;
                n_sh  = {r_sh[lslf_pkg::DIVN_W-2:0], ge};
            end
            if (last_step) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= lslf_pkg::OP_MUL;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_sh  <= n_sh;
        r_opr <= n_opr;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_acc[lslf_pkg::PROD_W-1:0];
    assign o_quot     = r_sh;

endmodule

// ===== src/least_squares_line_fit.sv =====
// top level: sample accumulation, line fit sequencer and prediction queries
//
// Streams (time, quantity) training samples and prediction queries. A training
// sample runs through ST_XX, ST_XY and ST_ACC, where the 16x16 products x*x
// and x*y are formed and added to the sums in turn. A sample with tlast set
// then runs the fit: six multiplications and two divisions on the shared
// add/subtract unit, which settles one multiplier bit or one quotient bit per
// cycle, or just two multiplications when the fit is singular. A query takes
// one multiplication, then adds, scales and saturates in ST_Q_SUM and ST_Q_OUT;
// with no model it goes to ST_Q_OUT and answers 1000 with model_valid low. The
// input is not ready while an item is in work; a finished result waits in the
// output register, and a query whose result finds it full holds up the input.
// Reset clears the sums and the model; no clearing pass follows.
module least_squares_line_fit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // tdata: time_value[15:0], quantity_value[31:16], query_minute[47:32]
    input  logic [47:0]                 i_s_axis_tdata,
    // tuser: command[0], first_sample[1]
    input  logic [1:0]                  i_s_axis_tuser,
    // tlast: last_sample
    input  logic                        i_s_axis_tlast,
    // result stream
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // tdata: prediction[31:0]
    output logic [31:0]                 o_m_axis_tdata,
    // tuser: model_valid[0]
    output logic [0:0]                  o_m_axis_tuser
);

    typedef enum logic [14:0] {
        ST_IDLE   = 15'h0001,
        ST_XX     = 15'h0002,
        ST_XY     = 15'h0004,
        ST_ACC    = 15'h0008,
        ST_F_P    = 15'h0010,
        ST_F_S    = 15'h0020,
        ST_F_T1   = 15'h0040,
        ST_F_T2   = 15'h0080,
        ST_F_DIVS = 15'h0100,
        ST_F_T3   = 15'h0200,
        ST_F_T4   = 15'h0400,
        ST_F_DIVI = 15'h0800,
        ST_Q_MUL  = 15'h1000,
        ST_Q_SUM  = 15'h2000,
        ST_Q_OUT  = 15'h4000
    } t_state;

    // control and model state
    t_state                             r_state, n_state;
    logic                               r_go, n_go;
    logic [lslf_pkg::CNT_W-1:0]         r_count, n_count;
    logic [lslf_pkg::SX_W-1:0]          r_sum_x, n_sum_x;
    logic [lslf_pkg::SX_W-1:0]          r_sum_y, n_sum_y;
    logic [lslf_pkg::SXX_W-1:0]         r_sum_xx, n_sum_xx;
    logic [lslf_pkg::SXX_W-1:0]         r_sum_xy, n_sum_xy;
    logic [lslf_pkg::COEF_W-1:0]        r_slope, n_slope;
    logic [lslf_pkg::COEF_W-1:0]        r_intercept, n_intercept;
    logic                               r_fitted, n_fitted;
    logic                               r_out_valid, n_out_valid;

    // working registers
    logic [lslf_pkg::X_W-1:0]           r_x, n_x;
    logic [lslf_pkg::X_W-1:0]           r_y, n_y;
    logic [lslf_pkg::X_W-1:0]           r_minute, n_minute;
    logic                               r_add, n_add;
    logic                               r_last, n_last;
    logic [2*lslf_pkg::X_W-1:0]         r_mprod, n_mprod;
    logic [lslf_pkg::PROD_W-1:0]        r_tmp, n_tmp;
    logic                               r_neg, n_neg;
    logic [lslf_pkg::D_W-1:0]           r_den, n_den;
    logic [lslf_pkg::ACC_W-1:0]         r_wide, n_wide;
    logic                               r_nomodel, n_nomodel;
    logic [lslf_pkg::PRED_W-1:0]        r_out_pred, n_out_pred;
    logic                               r_out_flag, n_out_flag;

    // shared unit connections
    lslf_pkg::t_unit_req                u_req;
    lslf_pkg::t_unit_sts                u_sts;
    logic [lslf_pkg::MULA_W-1:0]        u_mul_a;
    logic [lslf_pkg::MULB_W-1:0]        u_mul_b;
    logic [lslf_pkg::DIVN_W-1:0]        u_div_n;
    logic [lslf_pkg::D_W-1:0]           u_div_d;
    logic [lslf_pkg::PROD_W-1:0]        u_prod;
    logic [lslf_pkg::DIVN_W-1:0]        u_quot;

    // input fields
    logic                               in_cmd, in_first, in_last;
    logic [lslf_pkg::X_W-1:0]           in_x, in_y, in_min;
    logic                               in_accept;

    // datapath helpers
    logic [lslf_pkg::PROD_W:0]          diff_ab, diff_ba;
    logic                               tmp_lt_prod;
    logic [lslf_pkg::COEF_W-1:0]        slope_mag;
    logic [lslf_pkg::ACC_W-1:0]         q_bias, q_biased;
    logic [lslf_pkg::Q_W-1:0]           q_val;
    logic                               q_over_pos, q_over_neg;
    logic [lslf_pkg::PRED_W-1:0]        q_pred;
    logic                               out_free;

    assign in_cmd    = i_s_axis_tuser[0];
    assign in_first  = i_s_axis_tuser[1];
    assign in_last   = i_s_axis_tlast;
    assign in_x      = i_s_axis_tdata[15:0];
    assign in_y      = i_s_axis_tdata[31:16];
    assign in_min    = i_s_axis_tdata[47:32];
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_out_valid || i_m_axis_tready;

    // signed quotient magnitude clipped to the coefficient range
    function automatic logic [lslf_pkg::COEF_W-1:0] sat_coef(
        input logic [lslf_pkg::DIVN_W-1:0] q,
        input logic                        neg
    );
        logic [lslf_pkg::COEF_W-1:0] lim;
        logic [lslf_pkg::COEF_W-1:0] v;
        logic                        over;
        lim  = neg ? {1'b1, {(lslf_pkg::COEF_W-1){1'b0}}}
                   : {1'b0, {(lslf_pkg::COEF_W-1){1'b1}}};
        over = (|q[lslf_pkg::DIVN_W-1:lslf_pkg::COEF_W])
            || (q[lslf_pkg::COEF_W-1:0] > lim);
        v    = over ? lim : q[lslf_pkg::COEF_W-1:0];
        return neg ? (~v + 1'b1) : v;
    endfunction

    // product compares and magnitudes
    always_comb begin
        diff_ab     = {1'b0, r_tmp} - {1'b0, u_prod};
        diff_ba     = {1'b0, u_prod} - {1'b0, r_tmp};
        tmp_lt_prod = diff_ab[lslf_pkg::PROD_W];
        slope_mag   = r_slope[lslf_pkg::COEF_W-1] ? (~r_slope + 1'b1) : r_slope;
    end

    // prediction scaling: truncate toward zero, then clip to 32 bits
    always_comb begin
        q_bias     = r_wide[lslf_pkg::ACC_W-1]
                   ? lslf_pkg::ACC_W'((64'd1 << lslf_pkg::FRAC_BITS) - 64'd1) : '0;
        q_biased   = r_wide + q_bias;
        q_val      = q_biased[lslf_pkg::ACC_W-1:lslf_pkg::FRAC_BITS];
        q_over_pos = !q_val[lslf_pkg::Q_W-1]
                   && (|q_val[lslf_pkg::Q_W-2:lslf_pkg::PRED_W-1]);
        q_over_neg = q_val[lslf_pkg::Q_W-1]
                   && !(&q_val[lslf_pkg::Q_W-2:lslf_pkg::PRED_W-1]);
        if (q_over_pos) begin
            q_pred = {1'b0, {(lslf_pkg::PRED_W-1){1'b1}}};
        end else if (q_over_neg) begin
            q_pred = {1'b1, {(lslf_pkg::PRED_W-1){1'b0}}};
        end else begin
            q_pred = q_val[lslf_pkg::PRED_W-1:0];
        end
    end

    // shared unit operand selection
    always_comb begin
        u_req.start = r_go && !u_sts.busy;
        u_req.op    = lslf_pkg::OP_MUL;
        u_mul_a     = '0;
        u_mul_b     = '0;
        u_div_n     = {r_tmp, {lslf_pkg::FRAC_BITS{1'b0}}};
        u_div_d     = r_den;
        unique case (r_state)
            ST_F_P: begin
                u_mul_a = lslf_pkg::MULA_W'(r_sum_xx);
                u_mul_b = lslf_pkg::MULB_W'(r_count);
            end
            ST_F_S: begin
                u_mul_a = lslf_pkg::MULA_W'(r_sum_x);
                u_mul_b = r_sum_x;
            end
            ST_F_T1: begin
                u_mul_a = lslf_pkg::MULA_W'(r_sum_xy);
                u_mul_b = lslf_pkg::MULB_W'(r_count);
            end
            ST_F_T2: begin
                u_mul_a = lslf_pkg::MULA_W'(r_sum_y);
                u_mul_b = r_sum_x;
            end
            ST_F_T3: begin
                u_mul_a = lslf_pkg::MULA_W'(r_sum_xx);
                u_mul_b = r_sum_y;
            end
            ST_F_T4: begin
                u_mul_a = lslf_pkg::MULA_W'(r_sum_xy);
                u_mul_b = r_sum_x;
            end
            ST_F_DIVS, ST_F_DIVI: begin
                u_req.op = lslf_pkg::OP_DIV;
            end
            ST_Q_MUL: begin
                u_mul_a = lslf_pkg::MULA_W'(slope_mag);
                u_mul_b = lslf_pkg::MULB_W'(r_minute);
            end
            default: begin
                u_req.op = lslf_pkg::OP_MUL;
            end
        endcase
    end

    // sequencer
    always_comb begin
        logic [lslf_pkg::CNT_W-1:0] count_c;
        logic [lslf_pkg::SX_W-1:0]  sx_c, sy_c;
        logic                       add_c;

        n_state     = r_state;
        n_go        = r_go && !u_req.start;
        n_count     = r_count;
        n_sum_x     = r_sum_x;
        n_sum_y     = r_sum_y;
        n_sum_xx    = r_sum_xx;
        n_sum_xy    = r_sum_xy;
        n_slope     = r_slope;
        n_intercept = r_intercept;
        n_fitted    = r_fitted;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_x         = r_x;
        n_y         = r_y;
        n_minute    = r_minute;
        n_add       = r_add;
        n_last      = r_last;
        n_mprod     = r_mprod;
        n_tmp       = r_tmp;
        n_neg       = r_neg;
        n_den       = r_den;
        n_wide      = r_wide;
        n_nomodel   = r_nomodel;
        n_out_pred  = r_out_pred;
        n_out_flag  = r_out_flag;

        count_c = in_first ? '0 : r_count;
        sx_c    = in_first ? '0 : r_sum_x;
        sy_c    = in_first ? '0 : r_sum_y;
        add_c   = count_c < lslf_pkg::CNT_W'(lslf_pkg::MAX_SAMPLES);

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (!in_cmd) begin
                        // training sample: clear on first, add x and y now
                        n_count  = count_c;
                        n_sum_x  = sx_c;
                        n_sum_y  = sy_c;
                        n_sum_xx = in_first ? '0 : r_sum_xx;
                        n_sum_xy = in_first ? '0 : r_sum_xy;
                        if (add_c) begin
                            n_count = count_c + 1'b1;
                            n_sum_x = sx_c + lslf_pkg::SX_W'(in_x);
                            n_sum_y = sy_c + lslf_pkg::SX_W'(in_y);
                        end
                        n_add   = add_c;
                        n_last  = in_last;
                        n_x     = in_x;
                        n_y     = in_y;
                        n_state = ST_XX;
                    end else if (!r_fitted) begin
                        n_nomodel = 1'b1;
                        n_state   = ST_Q_OUT;
                    end else begin
                        n_nomodel = 1'b0;
                        n_minute  = in_min;
                        n_go      = 1'b1;
                        n_state   = ST_Q_MUL;
                    end
                end
            end
            ST_XX: begin
                n_mprod = (2*lslf_pkg::X_W)'(r_x) * (2*lslf_pkg::X_W)'(r_x);
                n_state = ST_XY;
            end
            ST_XY: begin
                if (r_add) begin
                    n_sum_xx = r_sum_xx + lslf_pkg::SXX_W'(r_mprod);
                end
                n_mprod = (2*lslf_pkg::X_W)'(r_x) * (2*lslf_pkg::X_W)'(r_y);
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (r_add) begin
                    n_sum_xy = r_sum_xy + lslf_pkg::SXX_W'(r_mprod);
                end
                if (r_last) begin
                    n_go    = 1'b1;
                    n_state = ST_F_P;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            // n*Sxx
            ST_F_P: begin
                if (u_sts.done) begin
                    n_tmp   = u_prod;
                    n_go    = 1'b1;
                    n_state = ST_F_S;
                end
            end
            // Sx*Sx, then the determinant
            ST_F_S: begin
                if (u_sts.done) begin
                    if (!tmp_lt_prod && (diff_ab != '0)) begin
                        n_den   = diff_ab[lslf_pkg::D_W-1:0];
                        n_go    = 1'b1;
                        n_state = ST_F_T1;
                    end else begin
                        n_fitted = 1'b0;
                        n_state  = ST_IDLE;
                    end
                end
            end
            // n*Sxy
            ST_F_T1: begin
                if (u_sts.done) begin
                    n_tmp   = u_prod;
                    n_go    = 1'b1;
                    n_state = ST_F_T2;
                end
            end
            // Sx*Sy, then sign and magnitude of the slope numerator
            ST_F_T2: begin
                if (u_sts.done) begin
                    n_neg   = tmp_lt_prod;
                    n_tmp   = tmp_lt_prod ? diff_ba[lslf_pkg::PROD_W-1:0]
                                          : diff_ab[lslf_pkg::PROD_W-1:0];
                    n_go    = 1'b1;
                    n_state = ST_F_DIVS;
                end
            end
            ST_F_DIVS: begin
                if (u_sts.done) begin
                    n_slope = sat_coef(u_quot, r_neg);
                    n_go    = 1'b1;
                    n_state = ST_F_T3;
                end
            end
            // Sy*Sxx
            ST_F_T3: begin
                if (u_sts.done) begin
                    n_tmp   = u_prod;
                    n_go    = 1'b1;
                    n_state = ST_F_T4;
                end
            end
            // Sx*Sxy, then sign and magnitude of the intercept numerator
            ST_F_T4: begin
                if (u_sts.done) begin
                    n_neg   = tmp_lt_prod;
                    n_tmp   = tmp_lt_prod ? diff_ba[lslf_pkg::PROD_W-1:0]
                                          : diff_ab[lslf_pkg::PROD_W-1:0];
                    n_go    = 1'b1;
                    n_state = ST_F_DIVI;
                end
            end
            ST_F_DIVI: begin
                if (u_sts.done) begin
                    n_intercept = sat_coef(u_quot, r_neg);
                    n_fitted    = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            // |slope|*minute
            ST_Q_MUL: begin
                if (u_sts.done) begin
                    n_tmp   = u_prod;
                    n_state = ST_Q_SUM;
                end
            end
            // intercept plus signed product
            ST_Q_SUM: begin
                n_wide = {{(lslf_pkg::ACC_W - lslf_pkg::COEF_W){r_intercept[lslf_pkg::COEF_W-1]}},
                          r_intercept}
                       + (r_tmp[lslf_pkg::ACC_W-1:0] ^ {lslf_pkg::ACC_W{r_slope[lslf_pkg::COEF_W-1]}})
                       + lslf_pkg::ACC_W'(r_slope[lslf_pkg::COEF_W-1]);
                n_state = ST_Q_OUT;
            end
            // result beat into the output register
            ST_Q_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pred  = r_nomodel ? lslf_pkg::DEFAULT_PREDICTION : q_pred;
                    n_out_flag  = !r_nomodel;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and model registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_go        <= 1'b0;
            r_count     <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_xx    <= '0;
            r_sum_xy    <= '0;
            r_slope     <= '0;
            r_intercept <= '0;
            r_fitted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_go        <= n_go;
            r_count     <= n_count;
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_sum_xx    <= n_sum_xx;
            r_sum_xy    <= n_sum_xy;
            r_slope     <= n_slope;
            r_intercept <= n_intercept;
            r_fitted    <= n_fitted;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_minute   <= n_minute;
        r_add      <= n_add;
        r_last     <= n_last;
        r_mprod    <= n_mprod;
        r_tmp      <= n_tmp;
        r_neg      <= n_neg;
        r_den      <= n_den;
        r_wide     <= n_wide;
        r_nomodel  <= n_nomodel;
        r_out_pred <= n_out_pred;
        r_out_flag <= n_out_flag;
    end

    // shared multiply and divide unit
    lslf_seq_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req),
        .i_mul_a (u_mul_a),
        .i_mul_b (u_mul_b),
        .i_div_n (u_div_n),
        .i_div_d (u_div_d),
        .o_sts   (u_sts),
        .o_prod  (u_prod),
        .o_quot  (u_quot)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_pred;
    assign o_m_axis_tuser  = r_out_flag;

endmodule

// ===== src/lslf_checker.sv =====
// port-level checker for the line fit block and its bind
module lslf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // an answer without a model carries the default value
    a_default_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |->
            o_m_axis_tdata == lslf_pkg::DEFAULT_PREDICTION)
        else $error("no-model answer is not the default prediction");

    // each accepted beat takes the input out of ready
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after an accepted beat");

    // a new result appears as the sequencer returns to idle
    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> o_s_axis_tready)
        else $error("result shown while the input is still busy");

endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ===== tb/tb_least_squares_line_fit.sv =====
// testbench for the least-squares line fit block: directed and random streams checked by a scoreboard
module tb_least_squares_line_fit;
    timeunit 1ns;
    timeprecision 1ps;

    // command field codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // run limits
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_CYCLES  = 3000;
    localparam int LONG_RUN     = 1028;
    localparam int PHASE_LEN    = 343;
    localparam int FIT_GAP      = 48;

    // fixed-point scale and prediction range
    localparam logic signed [79:0] FIX_ONE  = 80'sd1 <<< lslf_pkg::FRAC_BITS;
    localparam longint             PRED_MAX = 64'sh7FFF_FFFF;
    localparam longint             PRED_MIN = -PRED_MAX - 1;

    typedef struct {
        logic [lslf_pkg::PRED_W-1:0] prediction;
        logic                        model_valid;
    } t_fit_answer;

    // scoreboard: running sums, fitted line and the answers still owed
    class t_fit_scoreboard;
        logic [127:0]                       count, sx, sy, sxx, sxy;
        logic signed [lslf_pkg::COEF_W-1:0] icept, slp;
        bit                                 have_model;
        t_fit_answer                        answers_due[$];
        int                                 errors;

        function new();
            count = 0;
            sx = 0;
            sy = 0;
            sxx = 0;
            sxy = 0;
            icept = 0;
            slp = 0;
            have_model = 0;
            errors = 0;
        endfunction

        // (a - b) * 2^FRAC_BITS / d, truncated toward zero, clamped to the coefficient range
        function logic signed [lslf_pkg::COEF_W-1:0] ratio_to_coef(logic [127:0] a,
                                                                   logic [127:0] b,
                                                                   logic [127:0] d);
            logic         neg;
            logic [127:0] mag, quot, lim;
            neg  = a < b;
            mag  = neg ? b - a : a - b;
            quot = (mag << lslf_pkg::FRAC_BITS) / d;
            lim  = neg ? (128'd1 << (lslf_pkg::COEF_W - 1))
                       : (128'd1 << (lslf_pkg::COEF_W - 1)) - 128'd1;
            if (quot > lim) begin
                quot = lim;
            end
            return neg ? -quot[lslf_pkg::COEF_W-1:0] : quot[lslf_pkg::COEF_W-1:0];
        endfunction

        // update the sums or the line for one accepted input beat
        function void note_input(logic cmd, logic first, logic last,
                                 logic [15:0] x, logic [15:0] y, logic [15:0] minute);
            logic [127:0]       p, s, d;
            logic signed [79:0] acc, quo;
            t_fit_answer        ans;
            if (cmd == CMD_SAMPLE) begin
                if (first) begin
                    count = 0;
                    sx = 0;
                    sy = 0;
                    sxx = 0;
                    sxy = 0;
                end
                if (count < 128'(lslf_pkg::MAX_SAMPLES)) begin
                    count += 128'd1;
                    sx  += 128'(x);
                    sy  += 128'(y);
                    sxx += 128'(x) * 128'(x);
                    sxy += 128'(x) * 128'(y);
                end
                // normal equations, singular when fewer than two distinct times
                if (last) begin
                    p = count * sxx;
                    s = sx * sx;
                    if (s >= p) begin
                        have_model = 0;
                    end else begin
                        d = p - s;
                        slp   = ratio_to_coef(count * sxy, sx * sy, d);
                        icept = ratio_to_coef(sy * sxx, sx * sxy, d);
                        have_model = 1;
                    end
                end
                return;
            end
            if (!have_model) begin
                ans.prediction  = lslf_pkg::DEFAULT_PREDICTION;
                ans.model_valid = 1'b0;
            end else begin
                acc = 80'(icept) + 80'(slp) * 80'($signed({1'b0, minute}));
                quo = acc / FIX_ONE;
                if (quo > PRED_MAX) begin
                    ans.prediction = 32'h7FFF_FFFF;
                end else if (quo < PRED_MIN) begin
                    ans.prediction = 32'h8000_0000;
                end else begin
                    ans.prediction = quo[lslf_pkg::PRED_W-1:0];
                end
                ans.model_valid = 1'b1;
            end
            answers_due.insert(answers_due.size(), ans);
        endfunction

        // compare one result beat with the oldest answer owed
        function void check_result(logic [lslf_pkg::PRED_W-1:0] prediction, logic model_valid);
            t_fit_answer want;
            if (answers_due.size() == 0) begin
                $display("%0t: result beat with nothing owed: prediction %0d, model_valid %0b",
                         $realtime, $signed(prediction), model_valid);
                errors++;
                return;
            end
            want = answers_due.pop_front();
            if (prediction !== want.prediction) begin
                $display("%0t: prediction mismatch: expected %0d, actual %0d",
                         $realtime, $signed(want.prediction), $signed(prediction));
                errors++;
            end
            if (model_valid !== want.model_valid) begin
                $display("%0t: model_valid mismatch: expected %0b, actual %0b",
                         $realtime, want.model_valid, model_valid);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata;
    logic [1:0]  i_s_axis_tuser;
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;

    t_fit_scoreboard board = new();
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    bit              stall_request = 0;
    int              items_sent = 0;
    int              cycles = 0;

    least_squares_line_fit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // offer one beat after a random gap and wait until it is taken
    task automatic send_beat(logic cmd, logic first, logic last,
                             logic [15:0] x, logic [15:0] y, logic [15:0] minute);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {minute, y, x};
        i_s_axis_tuser  <= {first, cmd};
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        board.note_input(cmd, first, last, x, y, minute);
        items_sent++;
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int hold_left;
        bit stall_taken;
        hold_left = 0;
        stall_taken = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && stall_request && !stall_taken) begin
                hold_left = HOLD_CYCLES;
                stall_taken = 1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            board.check_result(o_m_axis_tdata, o_m_axis_tuser[0]);
        end
    end

    // stimulus
    initial begin
        logic last;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        i_s_axis_tlast  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // query before any fit, with flags and unused fields at their extremes
        send_beat(CMD_QUERY, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // first and last on one sample: singular
        send_beat(CMD_SAMPLE, 1'b1, 1'b1, 16'd100, 16'd200, 16'hFFFF);
        send_beat(CMD_QUERY, 1'b0, 1'b0, 16'd0, 16'd0, 16'd5);
        // rising diagonal across the full range
        send_beat(CMD_SAMPLE, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0);
        send_beat(CMD_SAMPLE, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'd0);
        send_beat(CMD_QUERY, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
        send_beat(CMD_QUERY, 1'b0, 1'b0, 16'd0, 16'd0, 16'hFFFF);
        send_beat(CMD_QUERY, 1'b0, 1'b0, 16'd0, 16'd0, 16'h8000);
        // steep fall: prediction clamps low
        send_beat(CMD_SAMPLE, 1'b1, 1'b0, 16'd0, 16'hFFFF, 16'd0);
        send_beat(CMD_SAMPLE, 1'b0, 1'b1, 16'd1, 16'd0, 16'd0);
        send_beat(CMD_QUERY, 1'b0, 1'b0, 16'd0, 16'd0, 16'hFFFF);
        send_beat(CMD_QUERY, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
        // steep rise: prediction clamps high
        send_beat(CMD_SAMPLE, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0);
        send_beat(CMD_SAMPLE, 1'b0, 1'b1, 16'd1, 16'hFFFF, 16'd0);
        send_beat(CMD_QUERY, 1'b0, 1'b0, 16'd0, 16'd0, 16'hFFFF);
        // steep rise far from zero: intercept clamps to the coefficient range
        send_beat(CMD_SAMPLE, 1'b1, 1'b0, 16'hFFFE, 16'd0, 16'd0);
        send_beat(CMD_SAMPLE, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'd0);
        send_beat(CMD_QUERY, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
        send_beat(CMD_QUERY, 1'b0, 1'b0, 16'd0, 16'd0, 16'hFFFF);
        // two samples at one time: model dropped
        send_beat(CMD_SAMPLE, 1'b1, 1'b0, 16'd7, 16'd1, 16'd0);
        send_beat(CMD_SAMPLE, 1'b0, 1'b1, 16'd7, 16'd9, 16'd0);
        send_beat(CMD_QUERY, 1'b0, 1'b1, 16'd0, 16'd0, 16'd3);

        // overlong training run with fits and queries along the way, spread over
        // receiver-heavy idling, sender-heavy idling, then none with a long hold-off;
        // sums stop at the sample limit and later fits use what was kept
        send_idle_pct = 34;
        recv_idle_pct = 71;
        for (int i = 0; i < LONG_RUN; i++) begin
            if (i == PHASE_LEN) begin
                send_idle_pct = 71;
                recv_idle_pct = 34;
            end else if (i == 2 * PHASE_LEN) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                stall_request = 1;
            end
            last = (i == LONG_RUN - 1) || ($urandom_range(FIT_GAP - 1) == 0);
            send_beat(CMD_SAMPLE, i == 0, last, 16'($urandom), 16'($urandom), 16'($urandom));
            if (last) begin
                repeat (2) begin
                    send_beat(CMD_QUERY, 1'($urandom), 1'($urandom), 16'($urandom),
                              16'($urandom),
                              $urandom_range(1) ? 16'($urandom_range(300)) : 16'($urandom));
                end
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (board.answers_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.answers_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== least_squares_line_fit.f =====
src/lslf_pkg.sv
src/lslf_seq_unit.sv
src/least_squares_line_fit.sv
src/lslf_checker.sv
tb/tb_least_squares_line_fit.sv
